>>> sv/stnv_pkg.sv
package stnv_pkg;

   localparam int FRAC_BITS_DEFAULT = 16;

   localparam int COORD_W = 32;
   localparam int DIFF_W  = COORD_W + 1;
   localparam int RSUM_W  = COORD_W + 3;
   localparam int ABSS_W  = COORD_W + 2;
   localparam int OFS3_W  = COORD_W + 2;
   localparam int PROD_W  = 2 * DIFF_W;
   localparam int DET_W   = PROD_W - 1;
   localparam int X_W     = DET_W + ABSS_W;
   localparam int LIMB_W  = 32;
   localparam int X_LIMBS = (X_W + LIMB_W - 1) / LIMB_W;
   localparam int PI_W    = 64;
   localparam int PI_LIMBS = PI_W / LIMB_W;
   localparam int P_W     = X_W + PI_W + 1;
   localparam int VOL_W   = 64;
   localparam int UC_W    = VOL_W + 1;

   localparam logic [PI_W-1:0] PI_Q62 = 64'hC90F_DAA2_2168_C235;

   // clamp for the scaled value before the divide by three
   localparam logic [UC_W-1:0] UC_LIMIT = 65'h1_8000_0000_0000_0003;

   localparam int DIGIT_W   = 16;
   localparam int N_DIGITS  = VOL_W / DIGIT_W;
   localparam int CUR_W     = DIGIT_W + 2;
   localparam int DIV_SHIFT = DIGIT_W + 4;
   localparam int RECIP_W   = DIGIT_W + 3;
   localparam logic [RECIP_W-1:0] RECIP3 = RECIP_W'(((1 << DIV_SHIFT) + 2) / 3);

   localparam logic [VOL_W-1:0] VOL_POS_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [VOL_W-1:0] VOL_NEG_MAG = 64'h8000_0000_0000_0000;

   localparam int FRONT_STAGES = 2;
   localparam int MAG_STAGES   = 4;
   localparam int SCALE_STAGES = 5;
   localparam int DIV_STAGES   = N_DIGITS + 1;
   localparam int N_STAGES     = FRONT_STAGES + MAG_STAGES + SCALE_STAGES + DIV_STAGES;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_IDX_W-1:0] CSR_AXIS_SELECT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_AXIS_OFFSET = 1'd1;

   typedef struct packed {
      logic signed [COORD_W-1:0] head_x;
      logic signed [COORD_W-1:0] head_y;
      logic signed [COORD_W-1:0] tail_x;
      logic signed [COORD_W-1:0] tail_y;
      logic signed [COORD_W-1:0] center_x;
      logic signed [COORD_W-1:0] center_y;
   } req_type;

   typedef struct packed {
      logic signed [VOL_W-1:0] head_volume;
      logic signed [VOL_W-1:0] tail_volume;
   } rsp_type;

   typedef struct packed {
      logic signed [DIFF_W-1:0] d_own;
      logic signed [DIFF_W-1:0] e_own;
      logic signed [DIFF_W-1:0] d_cen;
      logic signed [DIFF_W-1:0] e_cen;
      logic signed [RSUM_W-1:0] rsum;
   } lane_type;

endpackage

>>> sv/stnv_ctrl.sv
module stnv_ctrl import stnv_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                rsp_stall,
   output logic                req_stall,
   output logic                rsp_valid,
   output logic [N_STAGES-1:0] adv
);

   logic [N_STAGES-1:0] valid_ff;
   logic [N_STAGES-1:0] valid_in;

   // a stage moves when the output drains or it or some later stage holds a bubble
   for (genvar g = 0; g < N_STAGES; g++) begin : g_adv
      assign adv[g] = !rsp_stall || !(&valid_ff[N_STAGES-1:g]);
   end

   always_comb begin
      valid_in[0] = adv[0] ? req_valid : valid_ff[0];
      for (int i = 1; i < N_STAGES; i++) begin
         valid_in[i] = adv[i] ? valid_ff[i-1] : valid_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_stall = !adv[0];
   assign rsp_valid = valid_ff[N_STAGES-1];

endmodule

>>> sv/stnv_front.sv
module stnv_front import stnv_pkg::*; (
   input  logic                    clock,
   input  logic                    axis_select,
   input  logic signed [OFS3_W-1:0] offset3,
   input  logic [FRONT_STAGES-1:0] adv,
   input  req_type                 req_data,
   output lane_type                head_lane,
   output lane_type                tail_lane
);

   logic signed [COORD_W-1:0] hr_in, hz_in, tr_in, tz_in, cr_in, cz_in, mr_in, mz_in;
   logic signed [COORD_W-1:0] hr_ff, hz_ff, tr_ff, tz_ff, cr_ff, cz_ff, mr_ff, mz_ff;
   logic signed [COORD_W:0]   mr_sum, mz_sum;
   lane_type                  head_in, tail_in, head_ff, tail_ff;

   always_comb begin
      if (axis_select) begin
         hr_in = req_data.head_y;
         hz_in = req_data.head_x;
         tr_in = req_data.tail_y;
         tz_in = req_data.tail_x;
         cr_in = req_data.center_y;
         cz_in = req_data.center_x;
      end else begin
         hr_in = req_data.head_x;
         hz_in = req_data.head_y;
         tr_in = req_data.tail_x;
         tz_in = req_data.tail_y;
         cr_in = req_data.center_x;
         cz_in = req_data.center_y;
      end
      mr_sum = (COORD_W+1)'(hr_in) + (COORD_W+1)'(tr_in);
      mz_sum = (COORD_W+1)'(hz_in) + (COORD_W+1)'(tz_in);
      mr_in  = mr_sum[COORD_W:1];
      mz_in  = mz_sum[COORD_W:1];
   end

   always_comb begin
      head_in.d_own = DIFF_W'(hr_ff) - DIFF_W'(mr_ff);
      head_in.e_own = DIFF_W'(hz_ff) - DIFF_W'(mz_ff);
      head_in.d_cen = DIFF_W'(cr_ff) - DIFF_W'(mr_ff);
      head_in.e_cen = DIFF_W'(cz_ff) - DIFF_W'(mz_ff);
      head_in.rsum  = RSUM_W'(hr_ff) + RSUM_W'(cr_ff) + RSUM_W'(mr_ff) - RSUM_W'(offset3);
      tail_in.d_own = DIFF_W'(tr_ff) - DIFF_W'(mr_ff);
      tail_in.e_own = DIFF_W'(tz_ff) - DIFF_W'(mz_ff);
      tail_in.d_cen = head_in.d_cen;
      tail_in.e_cen = head_in.e_cen;
      tail_in.rsum  = RSUM_W'(tr_ff) + RSUM_W'(cr_ff) + RSUM_W'(mr_ff) - RSUM_W'(offset3);
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         hr_ff <= hr_in;
         hz_ff <= hz_in;
         tr_ff <= tr_in;
         tz_ff <= tz_in;
         cr_ff <= cr_in;
         cz_ff <= cz_in;
         mr_ff <= mr_in;
         mz_ff <= mz_in;
      end
      if (adv[1]) begin
         head_ff <= head_in;
         tail_ff <= tail_in;
      end
   end

   assign head_lane = head_ff;
   assign tail_lane = tail_ff;

endmodule

>>> sv/stnv_mag.sv
module stnv_mag import stnv_pkg::*; (
   input  logic                  clock,
   input  logic [MAG_STAGES-1:0] adv,
   input  lane_type              lane,
   output logic [X_W-1:0]        x,
   output logic                  neg
);

   localparam int HI_W  = DET_W - LIMB_W;
   localparam int PP0_W = LIMB_W + ABSS_W;
   localparam int PP1_W = HI_W + ABSS_W;

   logic signed [PROD_W-1:0] p1_in, p2_in, p1_ff, p2_ff;
   logic [ABSS_W-1:0]        abss_in, abss_ff, abss2_ff;
   logic                     neg_ff, neg2_ff, neg3_ff, neg4_ff;
   logic signed [PROD_W:0]   det;
   logic [DET_W-1:0]         absdet_in, absdet_ff;
   logic [PP0_W-1:0]         pp0_in, pp0_ff;
   logic [PP1_W-1:0]         pp1_in, pp1_ff;
   logic [X_W-1:0]           x_in, x_ff;

   always_comb begin
      p1_in   = PROD_W'(lane.d_own) * PROD_W'(lane.e_cen);
      p2_in   = PROD_W'(lane.d_cen) * PROD_W'(lane.e_own);
      abss_in = ABSS_W'(lane.rsum < 0 ? -lane.rsum : lane.rsum);
      det       = (PROD_W+1)'(p1_ff) - (PROD_W+1)'(p2_ff);
      absdet_in = DET_W'(det < 0 ? -det : det);
      pp0_in = PP0_W'(absdet_ff[LIMB_W-1:0]) * PP0_W'(abss2_ff);
      pp1_in = PP1_W'(absdet_ff[DET_W-1:LIMB_W]) * PP1_W'(abss2_ff);
      x_in   = X_W'(pp0_ff) + {pp1_ff, {LIMB_W{1'b0}}};
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         p1_ff   <= p1_in;
         p2_ff   <= p2_in;
         abss_ff <= abss_in;
         neg_ff  <= lane.rsum[RSUM_W-1];
      end
      if (adv[1]) begin
         absdet_ff <= absdet_in;
         abss2_ff  <= abss_ff;
         neg2_ff   <= neg_ff;
      end
      if (adv[2]) begin
         pp0_ff  <= pp0_in;
         pp1_ff  <= pp1_in;
         neg3_ff <= neg2_ff;
      end
      if (adv[3]) begin
         x_ff    <= x_in;
         neg4_ff <= neg3_ff;
      end
   end

   assign x   = x_ff;
   assign neg = neg4_ff;

endmodule

>>> sv/stnv_scale.sv
module stnv_scale import stnv_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  logic                    clock,
   input  logic [SCALE_STAGES-1:0] adv,
   input  logic [X_W-1:0]          x,
   input  logic                    neg_in,
   output logic [UC_W-1:0]         uc,
   output logic                    neg
);

   localparam int K     = 2 * FRAC_BITS + 62;
   localparam int U_W   = P_W - K;
   localparam int CMP_W = (U_W > UC_W) ? U_W : UC_W;
   localparam int ROW_W = 2 * LIMB_W + LIMB_W;
   localparam int AB_W  = ROW_W + LIMB_W;
   localparam logic [P_W-1:0] ROUND_BIAS = P_W'(3) << (K - 1);

   logic [X_LIMBS*LIMB_W-1:0] xw;
   logic [2*LIMB_W-1:0] pp_in [X_LIMBS][PI_LIMBS];
   logic [2*LIMB_W-1:0] pp_ff [X_LIMBS][PI_LIMBS];
   logic [ROW_W-1:0]    row_in [X_LIMBS];
   logic [ROW_W-1:0]    row_ff [X_LIMBS];
   logic [AB_W-1:0]     a_in, b_in, a_ff, b_ff;
   logic [P_W-1:0]      p_in, p_ff;
   logic [U_W-1:0]      u;
   logic [CMP_W-1:0]    u_ext;
   logic [UC_W-1:0]     uc_in, uc_ff;
   logic                neg1_ff, neg2_ff, neg3_ff, neg4_ff, neg5_ff;

   always_comb begin
      xw = (X_LIMBS*LIMB_W)'(x);
      for (int i = 0; i < X_LIMBS; i++) begin
         for (int j = 0; j < PI_LIMBS; j++) begin
            pp_in[i][j] = (2*LIMB_W)'(xw[LIMB_W*i +: LIMB_W])
                        * (2*LIMB_W)'(PI_Q62[LIMB_W*j +: LIMB_W]);
         end
         row_in[i] = ROW_W'(pp_ff[i][0]) + {pp_ff[i][1], {LIMB_W{1'b0}}};
      end
      a_in  = AB_W'(row_ff[0]) + {row_ff[1], {LIMB_W{1'b0}}};
      b_in  = AB_W'(row_ff[2]) + {row_ff[3], {LIMB_W{1'b0}}};
      p_in  = P_W'(a_ff) + {b_ff[P_W-2*LIMB_W-1:0], {(2*LIMB_W){1'b0}}} + ROUND_BIAS;
      u     = p_ff[P_W-1:K];
      u_ext = CMP_W'(u);
      uc_in = (u_ext >= CMP_W'(UC_LIMIT)) ? UC_LIMIT : UC_W'(u_ext);
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         pp_ff   <= pp_in;
         neg1_ff <= neg_in;
      end
      if (adv[1]) begin
         row_ff  <= row_in;
         neg2_ff <= neg1_ff;
      end
      if (adv[2]) begin
         a_ff    <= a_in;
         b_ff    <= b_in;
         neg3_ff <= neg2_ff;
      end
      if (adv[3]) begin
         p_ff    <= p_in;
         neg4_ff <= neg3_ff;
      end
      if (adv[4]) begin
         uc_ff   <= uc_in;
         neg5_ff <= neg4_ff;
      end
   end

   assign uc  = uc_ff;
   assign neg = neg5_ff;

endmodule

>>> sv/stnv_div3.sv
module stnv_div3 import stnv_pkg::*; (
   input  logic                   clock,
   input  logic [DIV_STAGES-1:0]  adv,
   input  logic [UC_W-1:0]        uc,
   input  logic                   neg_in,
   output logic signed [VOL_W-1:0] vol
);

   localparam int PRD_W = CUR_W + RECIP_W;

   logic [1:0]        rem_src  [N_DIGITS];
   logic [VOL_W-1:0]  word_src [N_DIGITS];
   logic [VOL_W-1:0]  quot_src [N_DIGITS];
   logic [N_DIGITS-1:0] neg_src;
   logic [1:0]        rem_in   [N_DIGITS];
   logic [VOL_W-1:0]  quot_in  [N_DIGITS];
   logic [1:0]        rem_ff   [N_DIGITS];
   logic [VOL_W-1:0]  word_ff  [N_DIGITS];
   logic [VOL_W-1:0]  quot_ff  [N_DIGITS];
   logic [N_DIGITS-1:0] neg_ff;
   logic [VOL_W-1:0]  mag, mag_sat;
   logic signed [VOL_W-1:0] vol_in, vol_ff;

   always_comb begin
      logic [CUR_W-1:0]   cur;
      logic [PRD_W-1:0]   prd;
      logic [DIGIT_W-1:0] q;
      logic [CUR_W-1:0]   rem_full;
      rem_src[0]  = {1'b0, uc[UC_W-1]};
      word_src[0] = uc[VOL_W-1:0];
      quot_src[0] = '0;
      neg_src[0]  = neg_in;
      for (int s = 1; s < N_DIGITS; s++) begin
         rem_src[s]  = rem_ff[s-1];
         word_src[s] = word_ff[s-1];
         quot_src[s] = quot_ff[s-1];
         neg_src[s]  = neg_ff[s-1];
      end
      for (int s = 0; s < N_DIGITS; s++) begin
         cur      = {rem_src[s], word_src[s][VOL_W-1-DIGIT_W*s -: DIGIT_W]};
         prd      = PRD_W'(cur) * PRD_W'(RECIP3);
         q        = prd[DIV_SHIFT +: DIGIT_W];
         rem_full = cur - CUR_W'({q, 1'b0}) - CUR_W'(q);
         rem_in[s]  = rem_full[1:0];
         quot_in[s] = quot_src[s];
         quot_in[s][VOL_W-1-DIGIT_W*s -: DIGIT_W] = q;
      end
   end

   always_comb begin
      mag = quot_ff[N_DIGITS-1];
      if (neg_ff[N_DIGITS-1]) begin
         mag_sat = (mag > VOL_NEG_MAG) ? VOL_NEG_MAG : mag;
         vol_in  = -$signed(mag_sat);
      end else begin
         mag_sat = (mag > VOL_POS_MAX) ? VOL_POS_MAX : mag;
         vol_in  = $signed(mag_sat);
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < N_DIGITS; s++) begin
         if (adv[s]) begin
            rem_ff[s]  <= rem_in[s];
            word_ff[s] <= word_src[s];
            quot_ff[s] <= quot_in[s];
            neg_ff[s]  <= neg_src[s];
         end
      end
      if (adv[N_DIGITS]) begin
         vol_ff <= vol_in;
      end
   end

   assign vol = vol_ff;

endmodule

>>> sv/swept_triangle_node_volume.sv
// Swept node volume of one triangle edge around a rotation axis.
// Request channel: req_valid/req_stall carry one edge (head, tail, center
// points, signed fixed point) in req_data; a request is taken on a rising
// edge with req_valid high and req_stall low.
// Response channel: rsp_valid/rsp_stall carry the head and tail volumes in
// rsp_data, one response per request, in request order.
// Configuration: csr_we/csr_index/csr_wdata write axis_select and
// axis_offset; write only while no request is in flight.
// One request is taken every cycle while req_stall is low. The depth is set by
// the 16-stage pipeline: coordinate setup, the cross-product multipliers, the
// multiply by pi split into 32-bit partial products, rounding, and a divide by
// three done one 16-bit digit a stage.
// Reset clears all stage valid bits and sets both registers to zero.
// When rsp_stall is high the response holds; earlier stages keep moving into
// empty slots, and req_stall rises only once all 16 stages hold requests.
module swept_triangle_node_volume import stnv_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int MAG_BASE   = FRONT_STAGES;
   localparam int SCALE_BASE = MAG_BASE + MAG_STAGES;
   localparam int DIV_BASE   = SCALE_BASE + SCALE_STAGES;

   logic                     axis_select_ff, axis_select_in;
   logic signed [OFS3_W-1:0] offset3_ff, offset3_in;
   logic signed [OFS3_W-1:0] wdata_ext;
   logic [N_STAGES-1:0]      adv;
   lane_type                 head_lane, tail_lane;
   logic [X_W-1:0]           head_x, tail_x;
   logic                     head_neg_m, tail_neg_m, head_neg_s, tail_neg_s;
   logic [UC_W-1:0]          head_uc, tail_uc;
   logic signed [VOL_W-1:0]  head_vol, tail_vol;

   always_comb begin
      axis_select_in = axis_select_ff;
      offset3_in     = offset3_ff;
      wdata_ext      = OFS3_W'($signed(csr_wdata));
      if (csr_we) begin
         unique case (csr_index)
            CSR_AXIS_SELECT: axis_select_in = csr_wdata[0];
            CSR_AXIS_OFFSET: offset3_in     = wdata_ext + (wdata_ext <<< 1);
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         axis_select_ff <= 1'b0;
         offset3_ff     <= '0;
      end else begin
         axis_select_ff <= axis_select_in;
         offset3_ff     <= offset3_in;
      end
   end

   stnv_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .rsp_stall (rsp_stall),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .adv       (adv)
   );

   stnv_front u_front (
      .clock       (clock),
      .axis_select (axis_select_ff),
      .offset3     (offset3_ff),
      .adv         (adv[FRONT_STAGES-1:0]),
      .req_data    (req_data),
      .head_lane   (head_lane),
      .tail_lane   (tail_lane)
   );

   stnv_mag u_head_mag (
      .clock (clock),
      .adv   (adv[MAG_BASE +: MAG_STAGES]),
      .lane  (head_lane),
      .x     (head_x),
      .neg   (head_neg_m)
   );

   stnv_mag u_tail_mag (
      .clock (clock),
      .adv   (adv[MAG_BASE +: MAG_STAGES]),
      .lane  (tail_lane),
      .x     (tail_x),
      .neg   (tail_neg_m)
   );

   stnv_scale #(.FRAC_BITS(FRAC_BITS)) u_head_scale (
      .clock  (clock),
      .adv    (adv[SCALE_BASE +: SCALE_STAGES]),
      .x      (head_x),
      .neg_in (head_neg_m),
      .uc     (head_uc),
      .neg    (head_neg_s)
   );

   stnv_scale #(.FRAC_BITS(FRAC_BITS)) u_tail_scale (
      .clock  (clock),
      .adv    (adv[SCALE_BASE +: SCALE_STAGES]),
      .x      (tail_x),
      .neg_in (tail_neg_m),
      .uc     (tail_uc),
      .neg    (tail_neg_s)
   );

   stnv_div3 u_head_div (
      .clock  (clock),
      .adv    (adv[DIV_BASE +: DIV_STAGES]),
      .uc     (head_uc),
      .neg_in (head_neg_s),
      .vol    (head_vol)
   );

   stnv_div3 u_tail_div (
      .clock  (clock),
      .adv    (adv[DIV_BASE +: DIV_STAGES]),
      .uc     (tail_uc),
      .neg_in (tail_neg_s),
      .vol    (tail_vol)
   );

   assign rsp_data = '{head_volume: head_vol, tail_volume: tail_vol};

endmodule
